// File: hdl/frdc_pkg.sv
// shared types and constants for the fit record delta coder
package frdc_pkg;

    localparam logic [3:0] PH_HDR_SIZE   = 4'd0;
    localparam logic [3:0] PH_HDR_BODY   = 4'd1;
    localparam logic [3:0] PH_REC        = 4'd2;
    localparam logic [3:0] PH_DEF_HEAD   = 4'd3;
    localparam logic [3:0] PH_DEF_FIELDS = 4'd4;
    localparam logic [3:0] PH_DATA       = 4'd5;
    localparam logic [3:0] PH_HALT       = 4'd6;

    localparam logic [1:0] ST_RUN      = 2'd0;
    localparam logic [1:0] ST_OVERSIZE = 2'd1;
    localparam logic [1:0] ST_NOSIG    = 2'd2;

    localparam int unsigned TYPES      = 16;
    localparam logic [7:0]  HDR_MAX    = 8'd20;
    localparam logic [7:0]  HDR_MIN    = 8'd12;

    // operation handed from the front part to the back part
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        valid_out;
        logic        delta;
        logic [3:0]  ctype;
        logic [8:0]  pos;
        logic        clear;
        logic [1:0]  status;
    } frdc_op_t;

    function automatic logic [7:0] sig_byte(input logic [1:0] i);
        logic [7:0] r;
        begin
            case (i)
                2'd0:    r = 8'h2E;
                2'd1:    r = 8'h46;
                2'd2:    r = 8'h49;
                default: r = 8'h54;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hdl/frdc_if.sv
// valid/ready channel interfaces
interface frdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface frdc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       was_delta;
    logic [1:0] status;
    modport source (output valid, output out_byte, output out_valid, output was_delta,
                    output status, input ready);
    modport sink (input valid, input out_byte, input out_valid, input was_delta,
                  input status, output ready);
endinterface

interface frdc_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/fit_record_delta_coder.sv
// fit record delta coder: one output item per input byte
// an accepted byte passes the stage 1 register and the output register; throughput:
// one byte per cycle unless stalled; the compare store read-modify-write is pipelined
// with a bypass for repeated entries; a stalled output holds off input after two items
// reset: asynchronous active low, parser waits for the header size byte,
// direction is encode, no type is defined; direction writes are taken only when idle
module fit_record_delta_coder #(
    parameter int unsigned STORE_BUDGET = 512,
    parameter int unsigned MAX_COMPARE  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    frdc_cfg_if.sink    cfg,
    frdc_in_if.sink     in_ch,
    frdc_out_if.source  out_ch
);
    import frdc_pkg::*;

    logic       dir_reg;
    logic       busy;
    logic       q_valid, q_ready;
    frdc_op_t   q_op;

    // direction changes only between items
    assign cfg.ready = !busy && !in_ch.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= 1'b0;
        else if (cfg.valid && cfg.ready)
            dir_reg <= cfg.data;
    end

    frdc_front #(.STORE_BUDGET(STORE_BUDGET), .MAX_COMPARE(MAX_COMPARE)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_byte(in_ch.in_byte),
        .q_ready(q_ready), .q_valid(q_valid), .q_op(q_op)
    );

    frdc_back #(.MAX_COMPARE(MAX_COMPARE)) u_back (
        .clk(clk), .rst_n(rst_n), .direction(dir_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
        .busy(busy), .res(out_ch)
    );

endmodule

// File: hdl/frdc_front.sv
// record parser: header check, definitions, budget bookkeeping
module frdc_front #(
    parameter int unsigned STORE_BUDGET = 512,
    parameter int unsigned MAX_COMPARE  = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                q_ready,
    output logic                q_valid,
    output frdc_pkg::frdc_op_t  q_op
);
    import frdc_pkg::*;

    localparam int unsigned BW = $clog2(STORE_BUDGET + 1);
    localparam int unsigned CW = $clog2(MAX_COMPARE + 1);

    logic [3:0]  phase_reg, phase_next;
    logic [4:0]  hsize_reg, hsize_next;
    logic [15:0] pos_reg, pos_next;
    logic        sig_reg, sig_next;
    logic [3:0]  ctype_reg, ctype_next;
    logic [7:0]  fleft_reg, fleft_next;
    logic [15:0] lsum_reg, lsum_next;
    logic [1:0]  halt_reg, halt_next;
    logic [BW-1:0] used_reg, used_next;
    logic [15:0] tlen_reg [TYPES];
    logic [CW-1:0] tcmp_reg [TYPES];

    logic        fin;
    logic [BW-1:0] fin_used;
    logic [CW-1:0] fin_cmp;
    logic [BW:0]   fin_sum;
    logic [BW-1:0] freed;
    logic [CW-1:0] old_cmp;
    logic [15:0] pos_inc;
    logic [3:0]  dtype;
    logic        fire;
    frdc_op_t    op;

    assign in_ready = q_ready;
    assign fire = in_valid && in_ready;
    assign q_valid = in_valid;
    assign q_op = op;
    assign pos_inc = pos_reg + 16'd1;
    assign old_cmp = tcmp_reg[ctype_reg];

    always_comb
    begin
        freed = (BW'(old_cmp) > used_reg) ? '0 : used_reg - BW'(old_cmp);
        fin_cmp = (lsum_reg > 16'(MAX_COMPARE)) ? CW'(MAX_COMPARE) : CW'(lsum_reg);
        fin_sum = {1'b0, freed} + (BW+1)'(fin_cmp);
        if (fin_sum > (BW+1)'(STORE_BUDGET))
        begin
            fin_used = BW'(STORE_BUDGET);
            fin_cmp = '0;
        end
        else
        begin
            fin_used = fin_sum[BW-1:0];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        hsize_next = hsize_reg;
        pos_next = pos_reg;
        sig_next = sig_reg;
        ctype_next = ctype_reg;
        fleft_next = fleft_reg;
        lsum_next = lsum_reg;
        halt_next = halt_reg;
        fin = 1'b0;
        dtype = '0;
        op = '0;
        op.in_byte = in_byte;
        op.valid_out = 1'b1;
        op.ctype = ctype_reg;
        op.pos = 9'(pos_reg);
        case (phase_reg)
            PH_HDR_SIZE:
            begin
                if (in_byte > HDR_MAX)
                begin
                    halt_next = ST_OVERSIZE;
                    phase_next = PH_HALT;
                end
                else
                begin
                    hsize_next = in_byte[4:0];
                    sig_next = 1'b1;
                    if (in_byte < HDR_MIN)
                    begin
                        halt_next = ST_NOSIG;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        pos_next = 16'd1;
                        phase_next = PH_HDR_BODY;
                    end
                end
            end
            PH_HDR_BODY:
            begin
                if (pos_reg >= 16'd8 && pos_reg <= 16'd11 &&
                    in_byte != sig_byte(pos_reg[1:0]))
                    sig_next = 1'b0;
                if (pos_inc >= 16'(hsize_reg))
                begin
                    if (sig_next)
                        phase_next = PH_REC;
                    else
                    begin
                        halt_next = ST_NOSIG;
                        phase_next = PH_HALT;
                    end
                end
                else
                    pos_next = pos_inc;
            end
            PH_REC:
            begin
                if (in_byte[7] || !in_byte[6])
                begin
                    dtype = in_byte[7] ? {2'b00, in_byte[6:5]} : in_byte[3:0];
                    ctype_next = dtype;
                    pos_next = '0;
                    phase_next = (tlen_reg[dtype] == 16'd0) ? PH_REC : PH_DATA;
                end
                else
                begin
                    ctype_next = in_byte[3:0];
                    pos_next = '0;
                    lsum_next = '0;
                    phase_next = PH_DEF_HEAD;
                end
            end
            PH_DEF_HEAD:
            begin
                if (pos_reg >= 16'd4)
                begin
                    fleft_next = in_byte;
                    pos_next = '0;
                    if (in_byte == 8'd0)
                        fin = 1'b1;
                    else
                        phase_next = PH_DEF_FIELDS;
                end
                else
                    pos_next = pos_inc;
            end
            PH_DEF_FIELDS:
            begin
                if (pos_reg == 16'd1)
                    lsum_next = lsum_reg + 16'(in_byte);
                pos_next = pos_inc;
                if (pos_inc >= 16'd3)
                begin
                    pos_next = '0;
                    fleft_next = fleft_reg - 8'd1;
                    if (fleft_next == 8'd0)
                        fin = 1'b1;
                end
            end
            PH_DATA:
            begin
                if (pos_reg < 16'(tcmp_reg[ctype_reg]))
                    op.delta = 1'b1;
                pos_next = pos_inc;
                if (pos_inc >= tlen_reg[ctype_reg] || pos_inc == 16'd0)
                    phase_next = PH_REC;
            end
            default:
            begin
                op.valid_out = 1'b0;
                op.in_byte = '0;
            end
        endcase
        if (fin)
        begin
            phase_next = PH_REC;
            op.clear = 1'b1;
        end
        op.status = halt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR_SIZE;
            hsize_reg <= '0;
            pos_reg <= '0;
            sig_reg <= 1'b1;
            ctype_reg <= '0;
            fleft_reg <= '0;
            lsum_reg <= '0;
            halt_reg <= ST_RUN;
            used_reg <= '0;
            for (int i = 0; i < TYPES; i++)
            begin
                tlen_reg[i] <= '0;
                tcmp_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            hsize_reg <= hsize_next;
            pos_reg <= pos_next;
            sig_reg <= sig_next;
            ctype_reg <= ctype_next;
            fleft_reg <= fleft_next;
            lsum_reg <= lsum_next;
            halt_reg <= halt_next;
            if (fin)
            begin
                used_reg <= fin_used;
                tlen_reg[ctype_reg] <= lsum_reg;
                tcmp_reg[ctype_reg] <= fin_cmp;
            end
        end
    end

endmodule

// File: hdl/frdc_back.sv
// delta unit: compare store read-modify-write, output register
module frdc_back #(
    parameter int unsigned MAX_COMPARE = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                direction,
    input  logic                q_valid,
    output logic                q_ready,
    input  frdc_pkg::frdc_op_t  q_op,
    output logic                busy,
    frdc_out_if.source          res
);
    import frdc_pkg::*;

    localparam int unsigned PW = (MAX_COMPARE > 1) ? $clog2(MAX_COMPARE) : 1;
    localparam int unsigned AW = 4 + PW;
    localparam int unsigned DEPTH = TYPES << PW;

    // per-type fill mark: compare bytes are written in order from index 0, so an
    // index at or above the mark has not been written since the last definition
    // and reads as zero
    logic [7:0] mem [DEPTH];
    logic [8:0] mark_reg [TYPES];

    // stage 1: op registered while the memory read happens
    logic       s1_valid_reg;
    frdc_op_t   s1_op_reg;
    logic [7:0] rd_reg;
    logic       s1_fresh;
    logic [7:0] prev;
    logic [7:0] res_byte;
    logic       out_full_reg;
    logic [7:0] ob_reg;
    logic       ov_reg, wd_reg;
    logic [1:0] st_reg;
    logic       s1_adv, take;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [PW-1:0] s1_idx;

    // bypass for a back-to-back write to the same entry
    logic       byp_reg;
    logic [7:0] byp_data_reg;

    assign take = q_valid && q_ready;
    assign s1_adv = !out_full_reg || res.ready;
    assign q_ready = !s1_valid_reg || s1_adv;
    assign busy = s1_valid_reg || out_full_reg;
    assign rd_addr = {q_op.ctype, q_op.pos[PW-1:0]};
    assign s1_idx = s1_op_reg.pos[PW-1:0];
    assign wr_addr = {s1_op_reg.ctype, s1_idx};
    assign s1_fresh = s1_op_reg.pos >= mark_reg[s1_op_reg.ctype];
    assign prev = s1_fresh ? 8'd0 : (byp_reg ? byp_data_reg : rd_reg);
    assign res_byte = direction ? s1_op_reg.in_byte + prev : s1_op_reg.in_byte - prev;

    always_ff @(posedge clk)
    begin
        if (take)
            rd_reg <= mem[rd_addr];
        if (s1_valid_reg && s1_adv && s1_op_reg.delta)
            mem[wr_addr] <= direction ? res_byte : s1_op_reg.in_byte;
        if (take)
        begin
            byp_reg <= s1_valid_reg && s1_adv && s1_op_reg.delta && wr_addr == rd_addr;
            byp_data_reg <= direction ? res_byte : s1_op_reg.in_byte;
        end
        if (take)
            s1_op_reg <= q_op;
        if (s1_valid_reg && s1_adv)
        begin
            ob_reg <= s1_op_reg.delta ? res_byte : s1_op_reg.in_byte;
            ov_reg <= s1_op_reg.valid_out;
            wd_reg <= s1_op_reg.delta;
            st_reg <= s1_op_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_full_reg <= 1'b0;
            for (int i = 0; i < TYPES; i++)
                mark_reg[i] <= '0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_valid_reg && s1_adv)
                out_full_reg <= 1'b1;
            else if (res.ready)
                out_full_reg <= 1'b0;
            if (s1_valid_reg && s1_adv)
            begin
                if (s1_op_reg.clear)
                    mark_reg[s1_op_reg.ctype] <= '0;
                else if (s1_op_reg.delta && s1_fresh)
                    mark_reg[s1_op_reg.ctype] <= s1_op_reg.pos + 9'd1;
            end
        end
    end

    assign res.valid = out_full_reg;
    assign res.out_byte = ob_reg;
    assign res.out_valid = ov_reg;
    assign res.was_delta = wd_reg;
    assign res.status = st_reg;

endmodule

// File: hdl/frdc_checker.sv
// port-level checks for the fit record delta coder
module frdc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_vld,
    input logic       out_rdy,
    input logic [7:0] out_byte,
    input logic       out_valid,
    input logic       was_delta,
    input logic [1:0] status
);
    import frdc_pkg::*;

    a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !out_valid |-> out_byte == 8'd0 && !was_delta)
        else $error("halted item carries data");
    a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !out_valid |-> status != ST_RUN)
        else $error("halted item with running status");
    a_delta_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && was_delta |-> status == ST_RUN && out_valid)
        else $error("delta item while halted");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !out_rdy |=> out_vld && $stable(out_byte))
        else $error("stalled result changed");
endmodule

bind fit_record_delta_coder frdc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_vld(out_ch.valid), .out_rdy(out_ch.ready),
    .out_byte(out_ch.out_byte), .out_valid(out_ch.out_valid),
    .was_delta(out_ch.was_delta), .status(out_ch.status)
);
